// ----- rtl/apc_pkg.sv -----
// shared types and constants for the amicable pair checker
package apc_pkg;

  localparam int IN_W = 16;
  localparam int SUM_W = 18;
  localparam logic [SUM_W-1:0] SUM_MAX = 18'h3ffff;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic lanes_done;
  } stat_t;

endpackage

// ----- rtl/apc_lane.sv -----
// proper divisor sum engine: trial divisors tracked by running quotient and remainder
module apc_lane #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic                    step,
  input  logic [NUMBER_WIDTH-1:0] number,
  output logic                    fin,
  output logic [NUMBER_WIDTH+2:0] sum,
  output logic [NUMBER_WIDTH-1:0] value
);

  localparam int W = NUMBER_WIDTH;
  localparam int SW = NUMBER_WIDTH + 3;

  logic [W-1:0]    n;
  logic [W-1:0]    d;
  logic [W-1:0]    q;
  logic signed [W:0] r;
  logic            r_neg;

  assign r_neg = r[W];
  assign value = n;

  // invariant: n == q * d + r once r is non-negative
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      d   <= W'(1);
      q   <= '0;
      r   <= '0;
      sum <= '0;
      fin <= 1'b1;
    end else if (load) begin
      n   <= number;
      d   <= W'(1);
      q   <= number;
      r   <= '0;
      sum <= '0;
      fin <= (number == '0);
    end else if (step && !fin) begin
      if (r_neg) begin
        r <= r + $signed({1'b0, d});
        q <= q - W'(1);
      end else begin
        if (r == '0 && d != n) begin
          sum <= sum + SW'(d);
        end
        if (d == n) begin
          fin <= 1'b1;
        end else begin
          d <= d + W'(1);
          r <= r - $signed({1'b0, q});
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    !r_neg |-> ($unsigned(r) < {1'b0, d}))
    else $error("remainder not below trial divisor");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    (n != '0) |-> (d <= n))
    else $error("trial divisor passed the number");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (fin && !load) |=> fin)
    else $error("finished lane restarted without a load");
`endif

endmodule

// ----- rtl/apc_datapath.sv -----
// datapath: two divisor sum lanes and the result register
module apc_datapath #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  apc_pkg::cmd_t               cmd,
  input  logic [NUMBER_WIDTH-1:0]     a,
  input  logic [NUMBER_WIDTH-1:0]     b,
  output apc_pkg::stat_t              stat,
  output logic                        done,
  output logic                        is_amicable,
  output logic                        bad_operand,
  output logic [apc_pkg::SUM_W-1:0]   first_divisor_sum,
  output logic [apc_pkg::SUM_W-1:0]   second_divisor_sum
);

  localparam int W = NUMBER_WIDTH;
  localparam int SW = NUMBER_WIDTH + 3;
  localparam int EW = (SW > apc_pkg::SUM_W) ? SW : apc_pkg::SUM_W;

  logic          fin_a, fin_b;
  logic [SW-1:0] sum_a, sum_b;
  logic [W-1:0]  na, nb;
  logic [EW-1:0] ext_a, ext_b;
  logic [apc_pkg::SUM_W-1:0] sat_a, sat_b;
  logic          bad;

  apc_lane #(.NUMBER_WIDTH(W)) u_lane_a (
    .clk(clk), .rst(rst), .load(cmd.load), .step(cmd.step),
    .number(a), .fin(fin_a), .sum(sum_a), .value(na)
  );

  apc_lane #(.NUMBER_WIDTH(W)) u_lane_b (
    .clk(clk), .rst(rst), .load(cmd.load), .step(cmd.step),
    .number(b), .fin(fin_b), .sum(sum_b), .value(nb)
  );

  assign stat.lanes_done = fin_a && fin_b;

  assign ext_a = EW'(sum_a);
  assign ext_b = EW'(sum_b);
  assign sat_a = (ext_a > EW'(apc_pkg::SUM_MAX)) ? apc_pkg::SUM_MAX
                                                 : ext_a[apc_pkg::SUM_W-1:0];
  assign sat_b = (ext_b > EW'(apc_pkg::SUM_MAX)) ? apc_pkg::SUM_MAX
                                                 : ext_b[apc_pkg::SUM_W-1:0];
  assign bad = (na == '0) || (nb == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      bad_operand        <= bad;
      is_amicable        <= !bad && (sum_a == SW'(nb)) && (sum_b == SW'(na));
      first_divisor_sum  <= sat_a;
      second_divisor_sum <= sat_b;
    end
  end

endmodule

// ----- rtl/apc_ctrl.sv -----
// controller state machine: load, run the lanes, report one result
module apc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  apc_pkg::stat_t stat,
  output apc_pkg::cmd_t  cmd,
  output logic           busy
);

  apc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      apc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = apc_pkg::ST_RUN;
        end
      end
      apc_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.lanes_done) begin
          state_next = apc_pkg::ST_REPORT;
        end
      end
      apc_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = apc_pkg::ST_IDLE;
      end
      default: begin
        state_next = apc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/amicable_pair_check.sv -----
// amicable pair checker top level: controller plus two-lane divisor sum datapath
// the time from start to done grows with the larger of first_number and second_number
// each lane makes one quotient/remainder update per cycle over every trial divisor
// throughput: one request at a time; busy stays high until the result is issued
// the result is shown for one cycle with done high; the receiver cannot stall it
// reset (rst, synchronous) returns the controller to idle and drops done
module amicable_pair_check #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [apc_pkg::IN_W-1:0]         first_number,
  input  logic [apc_pkg::IN_W-1:0]         second_number,
  output logic                             done,
  output logic                             is_amicable,
  output logic                             bad_operand,
  output logic [apc_pkg::SUM_W-1:0]        first_divisor_sum,
  output logic [apc_pkg::SUM_W-1:0]        second_divisor_sum
);

  apc_pkg::cmd_t  cmd;
  apc_pkg::stat_t stat;
  logic [NUMBER_WIDTH-1:0] a, b;

  assign a = NUMBER_WIDTH'(first_number);
  assign b = NUMBER_WIDTH'(second_number);

  apc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  apc_datapath #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .a(a), .b(b), .stat(stat), .done(done),
    .is_amicable(is_amicable), .bad_operand(bad_operand),
    .first_divisor_sum(first_divisor_sum),
    .second_divisor_sum(second_divisor_sum)
  );

endmodule
